[design/fmps_pkg.sv]
package fmps_pkg;

    // Widths fixed by the register map and the request fields
    localparam int BYTE_BITS     = 8;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 3;
    localparam int LEN_BITS      = 6;
    localparam int PAT_WORDS     = 4;
    localparam int PAT_BYTES     = 32;
    localparam int POS_OUT_BITS  = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PATTERN_0 = 3'd0,
        REG_PATTERN_1 = 3'd1,
        REG_PATTERN_2 = 3'd2,
        REG_PATTERN_3 = 3'd3,
        REG_LENGTH    = 3'd4
    } cfg_reg_t;

    typedef logic [PAT_BYTES-1:0][BYTE_BITS-1:0] pattern_t;

    typedef struct packed {
        logic                    found;
        logic [POS_OUT_BITS-1:0] position;
    } result_t;

endpackage

[design/fmps_cell.sv]
module fmps_cell
    import fmps_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  logic                 clk,
    input  logic                 shift_en,
    input  logic [BYTE_BITS-1:0] byte_in,
    input  pattern_t             pattern,
    input  logic [LEN_BITS-1:0]  length,
    output logic [BYTE_BITS-1:0] byte_out,
    output logic                 hit
);

    localparam logic [LEN_BITS-1:0] CELL_POS = LEN_BITS'(CELL_INDEX);

    logic [BYTE_BITS-1:0] byte_reg;
    logic [LEN_BITS-1:0]  pat_idx;
    logic [BYTE_BITS-1:0] pat_byte;
    logic                 active;

    // Cell j sees the newest byte at window slot j; it pairs with pattern byte len-1-j
    assign active  = (length > CELL_POS);
    assign pat_idx = length - CELL_POS - LEN_BITS'(1);

    always_comb
    begin
        if (pat_idx < LEN_BITS'(PAT_BYTES))
        begin
            pat_byte = pattern[pat_idx[$clog2(PAT_BYTES)-1:0]];
        end
        else
        begin
            pat_byte = '0;
        end
    end

    assign hit = !active || (byte_in == pat_byte);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

[design/fmps_result_buf.sv]
module fmps_result_buf
    import fmps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t out_data,
    output logic    full
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (out_valid_next)
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule

[design/first_match_pattern_scan_top.sv]
// First-occurrence pattern scan over a byte stream.
//
// Input channel: one data byte per request (data_byte, last_byte), valid/stall.
// last_byte closes a stream. Only that request yields a result request on the
// output channel: found, and match_position (start offset of the first full
// match, 0 when none). Other bytes yield nothing.
// Pattern (up to 32 bytes) and its length are set through the cfg_* write port
// between requests; a write takes effect for the next accepted byte.
// Throughput: one byte per cycle while in_stall is low, limited by the
// combinational compare across the row of window cells. The result of a
// stream is registered in the result buffer when its last byte is accepted.
// Output side: a result register plus one skid entry. in_stall rises only
// when both hold results, so streams keep flowing while a result waits.
// Reset: pattern cleared, length 1, stream state and queued results dropped.
// Positions saturate at 2^POSITION_BITS-1; matches ending at or past that are
// missed.
module first_match_pattern_scan_top
    import fmps_pkg::*;
#(
    parameter int MAX_PATTERN   = 32,
    parameter int POSITION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [BYTE_BITS-1:0]     data_byte,
    input  logic                     last_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     found,
    output logic [POS_OUT_BITS-1:0]  match_position
);

    localparam int                     CNT_W   = POSITION_BITS + 1;
    localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;
    localparam logic [LEN_BITS:0]      MAX_LEN = (LEN_BITS+1)'(MAX_PATTERN);

    // Configuration registers
    logic [PAT_WORDS-1:0][CFG_DATA_BITS-1:0] pat_word_reg;
    logic [LEN_BITS-1:0]                     pat_len_reg;
    pattern_t                                pattern;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_word_reg <= '0;
            pat_len_reg  <= LEN_BITS'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_0: pat_word_reg[0] <= cfg_data;
                REG_PATTERN_1: pat_word_reg[1] <= cfg_data;
                REG_PATTERN_2: pat_word_reg[2] <= cfg_data;
                REG_PATTERN_3: pat_word_reg[3] <= cfg_data;
                REG_LENGTH:    pat_len_reg     <= cfg_data[LEN_BITS-1:0];
                default:       ; // unmapped index: ignored
            endcase
        end
    end

    // byte 0 of word 0 lands in the low bits, same packing as the pattern array
    assign pattern = pat_word_reg;

    logic in_accept;
    assign in_accept = in_valid && !in_stall;

    // Window: a row of cells, slot 0 newest; each cell shifts its byte onward
    logic [MAX_PATTERN-1:0][BYTE_BITS-1:0] cell_byte;
    logic [MAX_PATTERN-1:0]                cell_hit;

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        logic [BYTE_BITS-1:0] byte_in;
        if (j == 0)
        begin : g_head
            assign byte_in = data_byte;
        end
        else
        begin : g_body
            assign byte_in = cell_byte[j-1];
        end

        fmps_cell #(
            .CELL_INDEX (j)
        ) u_cell (
            .clk      (clk),
            .shift_en (in_accept),
            .byte_in  (byte_in),
            .pattern  (pattern),
            .length   (pat_len_reg),
            .byte_out (cell_byte[j]),
            .hit      (cell_hit[j])
        );
    end

    // Stream state
    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic                     latched_reg, latched_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic                     len_ok;
    logic [CNT_W-1:0]         count_inc;
    logic                     test_en;
    result_t                  result;
    logic                     buf_full;
    result_t                  out_data;

    assign len_ok    = (pat_len_reg != '0) && ((LEN_BITS+1)'(pat_len_reg) <= MAX_LEN);
    assign count_inc = CNT_W'(count_reg) + CNT_W'(1);
    assign test_en   = !latched_reg && len_ok && (count_reg != POS_LIMIT)
                       && (count_inc >= CNT_W'(pat_len_reg));

    always_comb
    begin
        count_next   = count_reg;
        latched_next = latched_reg;
        start_next   = start_reg;
        result       = '0;
        if (in_accept)
        begin
            if (test_en && (&cell_hit))
            begin
                latched_next = 1'b1;
                start_next   = POSITION_BITS'(count_inc - CNT_W'(pat_len_reg));
            end
            if (count_reg != POS_LIMIT)
            begin
                count_next = count_inc[POSITION_BITS-1:0];
            end
            result.found    = latched_next;
            result.position = latched_next ? POS_OUT_BITS'(start_next) : '0;
            if (last_byte)
            begin
                count_next   = '0;
                latched_next = 1'b0;
                start_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            latched_reg <= 1'b0;
            start_reg   <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            latched_reg <= latched_next;
            start_reg   <= start_next;
        end
    end

    // Result register with skid entry
    fmps_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept && last_byte),
        .push_data (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign in_stall       = buf_full;
    assign found          = out_data.found;
    assign match_position = out_data.position;

endmodule

[design/fmps_checker.sv]
module fmps_checker
    import fmps_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    last_byte,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic                    found,
    input logic [POS_OUT_BITS-1:0] match_position
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_no_pos_when_missing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_position == '0)
        else $error("position set without a match");

    // input backs up only when a result is already waiting
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && last_byte))
        else $error("result without a closing byte");

endmodule

bind first_match_pattern_scan_top fmps_checker u_fmps_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 100ps

// Testbench for first_match_pattern_scan_top.
//
// Byte requests go in one per handshake; only the request flagged last_byte
// produces a result request (found, match_position). A tracker class keeps
// its own copy of the pattern registers and of the scan state (shift window,
// saturating byte offset, latched first start), works out the verdict for
// every stream and compares it with what comes out, oldest first.
//
// Order of the run:
//   - a short directed part: the default pattern, then lengths 0 and
//     above 32, a stray register index, a stream shorter than the pattern
//     and a match that starts at offset 0
//   - three random phases (sender/receiver idling 38/63, then 63/38, then
//     none), each going through several pattern settings; streams are mostly
//     random bytes with copies of the pattern, or cut-down prefixes of it,
//     spliced in
module testbench;
    import fmps_pkg::*;

    localparam int POSITION_BITS  = 16;
    localparam int POS_LIMIT      = (1 << POSITION_BITS) - 1;
    localparam int WORD_BYTES     = CFG_DATA_BITS / BYTE_BITS;
    localparam int REG_INDEX_TOP  = (1 << CFG_IDX_BITS) - 1;
    localparam int SETTLE_CYCLES  = 4;       // idle clocks that settle() adds after the last verdict
    localparam int BYTES_PER_PASS = 170;     // minimum bytes scanned per random phase
    localparam int MAX_SHOWN      = 10;
    localparam int CYCLE_LIMIT    = 1000000;

    // Reference behaviour: pattern registers, scan state, verdicts awaited
    class first_match_tracker;
        logic [CFG_DATA_BITS-1:0] pattern_words [PAT_WORDS];
        logic [LEN_BITS-1:0]      pat_len_cfg;
        logic [BYTE_BITS-1:0]     window [PAT_BYTES];
        logic [POSITION_BITS-1:0] byte_count;
        logic                     latched;
        logic [POSITION_BITS-1:0] first_start;
        result_t                  pending_verdicts [$];
        int unsigned              mismatches;
        int unsigned              bytes_noted;
        int unsigned              verdicts_seen;
        int unsigned              matches_seen;

        function new();
            foreach (pattern_words[i])
                pattern_words[i] = '0;
            pat_len_cfg   = LEN_BITS'(1);
            mismatches    = 0;
            bytes_noted   = 0;
            verdicts_seen = 0;
            matches_seen  = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (window[i])
                window[i] = '0;
            byte_count  = '0;
            latched     = 1'b0;
            first_start = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
                    pattern_words[idx] = value;
                REG_LENGTH:
                    pat_len_cfg = value[LEN_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [BYTE_BITS-1:0] pattern_byte(int k);
            return pattern_words[k / WORD_BYTES][(k % WORD_BYTES) * BYTE_BITS +: BYTE_BITS];
        endfunction

        function void note_request(logic [BYTE_BITS-1:0] b, logic last);
            int      len;
            logic    hit;
            result_t verdict;
            for (int i = PAT_BYTES - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = b;
            len = pat_len_cfg;
            bytes_noted++;
            // only the newest len bytes count; window[0] holds the pattern's last byte
            if (!latched && len >= 1 && len <= PAT_BYTES && byte_count < POS_LIMIT &&
                int'(byte_count) + 1 >= len)
            begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                    if (window[len-1-k] !== pattern_byte(k))
                        hit = 1'b0;
                if (hit)
                begin
                    latched     = 1'b1;
                    first_start = POSITION_BITS'(int'(byte_count) + 1 - len);
                end
            end
            if (byte_count < POS_LIMIT)
                byte_count++;
            if (last)
            begin
                verdict.found    = latched;
                verdict.position = latched ? POS_OUT_BITS'(first_start) : '0;
                pending_verdicts.push_back(verdict);
                clear_stream();
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("tb: %s", msg);
        endfunction

        function void check_verdict(logic got_found, logic [POS_OUT_BITS-1:0] got_pos);
            result_t want;
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
            begin
                flag($sformatf("result with none awaited: found %0b position %0d",
                               got_found, got_pos));
                return;
            end
            want = pending_verdicts.pop_front();
            if (want.found)
                matches_seen++;
            if (got_found !== want.found)
                flag($sformatf("found mismatch: expected %0b, got %0b", want.found, got_found));
            if (got_pos !== want.position)
                flag($sformatf("match_position mismatch: expected %0d, got %0d",
                               want.position, got_pos));
        endfunction
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [BYTE_BITS-1:0]     data_byte = '0;
    logic                     last_byte = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     found;
    logic [POS_OUT_BITS-1:0]  match_position;

    first_match_tracker tracker;

    // Stimulus state shared by the driving tasks
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    int unsigned          cycles        = 0;
    int unsigned          settings_used = 0;
    logic [BYTE_BITS-1:0] cur_pattern [PAT_BYTES];
    int                   cur_len;
    logic                 narrow_alphabet = 1'b0;
    logic [BYTE_BITS-1:0] alpha_base      = '0;
    logic [BYTE_BITS-1:0] stream_q [$];

    first_match_pattern_scan_top #(
        .MAX_PATTERN   (PAT_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .match_position (match_position)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: take a result request when valid and not stalled (pre-edge values),
    // then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_verdict(found, match_position);
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Narrow alphabet: three neighbouring values, so matches and near misses happen
    // by themselves; otherwise the full byte range
    function automatic logic [BYTE_BITS-1:0] pick_byte();
        if (narrow_alphabet)
            return BYTE_BITS'(alpha_base + $urandom_range(0, 2));
        return BYTE_BITS'($urandom_range(0, 255));
    endfunction

    // Sends stream_q as one stream, last_byte on its final request. Valid stays up
    // until the handshake; idle gaps only between requests.
    task automatic send_stream_q();
        for (int i = 0; i < stream_q.size(); i++)
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= stream_q[i];
            last_byte <= (i == stream_q.size() - 1);
            do
                @(posedge clk);
            while (in_stall);
            tracker.note_request(stream_q[i], i == stream_q.size() - 1);
        end
    endtask

    // Drop valid, wait for every awaited verdict, then let the pipe drain
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes all four pattern words from cur_pattern and the length register,
    // optionally followed by a write to an unused index (must be ignored)
    task automatic program_pattern(input logic [CFG_DATA_BITS-1:0] len_data, input bit stray);
        logic [CFG_DATA_BITS-1:0] word;
        logic [CFG_IDX_BITS-1:0]  idx;
        for (int w = REG_PATTERN_0; w <= REG_PATTERN_3; w++)
        begin
            for (int k = 0; k < WORD_BYTES; k++)
                word[k * BYTE_BITS +: BYTE_BITS] = cur_pattern[w * WORD_BYTES + k];
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_BITS'(w);
            cfg_data  <= word;
            @(posedge clk);
            tracker.write_reg(CFG_IDX_BITS'(w), word);
        end
        cfg_index <= REG_LENGTH;
        cfg_data  <= len_data;
        @(posedge clk);
        tracker.write_reg(REG_LENGTH, len_data);
        if (stray)
        begin
            idx  = CFG_IDX_BITS'($urandom_range(REG_LENGTH + 1, REG_INDEX_TOP));
            word = {$urandom, $urandom};
            cfg_index <= idx;
            cfg_data  <= word;
            @(posedge clk);
            tracker.write_reg(idx, word);
        end
        cfg_write <= 1'b0;
        cur_len = len_data[LEN_BITS-1:0];
        settings_used++;
    endtask

    initial
    begin
        int                       target;
        int                       embed_len;
        int                       cut;
        int                       len;
        int unsigned              phase_start;
        int                       setting;
        logic [CFG_DATA_BITS-1:0] len_data;

        tracker = new();
        foreach (cur_pattern[k])
            cur_pattern[k] = '0;
        cur_len       = 1;
        send_idle_pct = 38;
        recv_idle_pct = 63;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Reset pattern is one zero byte: match on the second byte, then a miss
        stream_q = '{8'h5A, 8'h00};
        send_stream_q();
        stream_q = '{8'hFF};
        send_stream_q();
        settle();

        // Length zero never matches; also a write to an unused index
        program_pattern('0, 1'b1);
        stream_q = '{8'h00};
        send_stream_q();
        settle();

        // Length above the window never matches, upper data bits set
        program_pattern({{(CFG_DATA_BITS - LEN_BITS){1'b1}}, 6'd63}, 1'b0);
        stream_q = '{8'h00, 8'h00};
        send_stream_q();
        settle();

        // Three-byte pattern, unused pattern bytes all ones
        foreach (cur_pattern[k])
            cur_pattern[k] = 8'hFF;
        cur_pattern[0] = 8'h41;
        cur_pattern[1] = 8'h42;
        cur_pattern[2] = 8'h43;
        program_pattern(CFG_DATA_BITS'(3), 1'b0);
        // stream shorter than the pattern
        stream_q = '{8'h41, 8'h42};
        send_stream_q();
        // first of two occurrences wins
        stream_q = '{8'h78, 8'h41, 8'h42, 8'h43, 8'h41, 8'h42, 8'h43};
        send_stream_q();
        // match filling the whole stream, start offset zero
        stream_q = '{8'h41, 8'h42, 8'h43};
        send_stream_q();
        settle();

        // ---- random phases ----
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 38; recv_idle_pct = 63; end
                1:       begin send_idle_pct = 63; recv_idle_pct = 38; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            phase_start = tracker.bytes_noted;
            setting     = 0;
            while (tracker.bytes_noted - phase_start < BYTES_PER_PASS)
            begin
                // full length and single byte first, then a spread incl. invalid ones
                if (setting == 0)
                    len = PAT_BYTES;
                else if (setting == 1)
                    len = 1;
                else
                begin
                    target = $urandom_range(0, 99);
                    if (target < 8)
                        len = PAT_BYTES;
                    else if (target < 14)
                        len = 1;
                    else if (target < 18)
                        len = 0;
                    else if (target < 24)
                        len = $urandom_range(PAT_BYTES + 1, (1 << LEN_BITS) - 1);
                    else if (target < 40)
                        len = $urandom_range(9, PAT_BYTES - 1);
                    else
                        len = $urandom_range(2, 8);
                end
                setting++;
                narrow_alphabet = 1'($urandom_range(0, 1));
                alpha_base      = BYTE_BITS'($urandom_range(0, 255));
                foreach (cur_pattern[k])
                    cur_pattern[k] = pick_byte();
                len_data = {$urandom, $urandom};
                len_data[LEN_BITS-1:0] = LEN_BITS'(len);
                program_pattern(len_data, $urandom_range(0, 3) == 0);

                repeat ($urandom_range(2, 5))
                begin
                    target    = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 80)
                                                             : $urandom_range(1, 40);
                    embed_len = (cur_len > PAT_BYTES) ? PAT_BYTES : cur_len;
                    stream_q.delete();
                    while (stream_q.size() < target)
                    begin
                        // splice in the pattern, sometimes only a prefix of it
                        if (embed_len != 0 && $urandom_range(0, 3) == 0)
                        begin
                            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, embed_len)
                                                               : embed_len;
                            for (int k = 0; k < cut; k++)
                                stream_q.push_back(cur_pattern[k]);
                        end
                        else
                            stream_q.push_back(pick_byte());
                    end
                    send_stream_q();
                end
                settle();
            end
        end

        $display("tb: %0d bytes scanned, %0d verdicts checked (%0d with a match), %0d settings",
                 tracker.bytes_noted, tracker.verdicts_seen, tracker.matches_seen,
                 settings_used);
        $display("tb: lengths 0 to 63, stray register index, both stall mixes and no stalls");
        if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
design/fmps_pkg.sv
design/fmps_cell.sv
design/fmps_result_buf.sv
design/first_match_pattern_scan_top.sv
design/fmps_checker.sv
dv/testbench.sv
